// ===== src/fermi_stochastic_state_hop_top_assert.svh =====
// assertion macros used by the checker file
`ifndef FERMI_STOCHASTIC_STATE_HOP_TOP_ASSERT_SVH
`define FERMI_STOCHASTIC_STATE_HOP_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define FSH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define FSH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fsh_pkg.sv =====
package fsh_pkg;

  typedef struct packed {
    logic [5:0]         bead_number;
    logic signed [31:0] energy_lower;
    logic signed [31:0] energy_upper;
    logic [15:0]        random_fraction;
    logic               final_bead;
  } fsh_in_t;

  typedef struct packed {
    logic signed [31:0] active_energy;
    logic               hopped;
    logic               new_surface;
    logic signed [39:0] energy_total;
    logic               last;
  } fsh_out_t;

  localparam logic [7:0] CFG_COUPLING  = 8'd0;
  localparam logic [7:0] CFG_TIME_STEP = 8'd1;
  localparam logic [7:0] CFG_BETA      = 8'd2;
  localparam logic [7:0] CFG_BIAS      = 8'd3;

  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 34;
  localparam int DIV_STEPS = 50;

  // round(2^32 / e)
  localparam logic [30:0] EXP_NEG_ONE = 31'd1580030169;
  // 100.0 in Q16.16
  localparam logic [23:0] ARG_MAX     = 24'd6553600;
  localparam logic [7:0]  WHOLE_LIMIT = 8'd24;
  localparam logic [3:0]  LAST_TERM   = 4'd12;
  localparam logic [16:0] F_ONE       = 17'd65536;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_resp_t;

  typedef struct packed {
    logic               start;
    logic signed [34:0] d;
  } fermi_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] f;
  } fermi_resp_t;

endpackage

// ===== src/fsh_div.sv =====
module fsh_div (
  input  logic                clk,
  input  logic                rst_n,
  input  fsh_pkg::div_req_t   req,
  output fsh_pkg::div_resp_t  resp
);

  logic                          busy_r;
  logic                          done_r;
  logic [5:0]                    cnt_r;
  logic [fsh_pkg::DIV_NUM_W-1:0] num_r;
  logic [fsh_pkg::DIV_DEN_W-1:0] den_r;
  logic [fsh_pkg::DIV_DEN_W-1:0] rem_r;
  logic [fsh_pkg::DIV_NUM_W-1:0] quo_r;
  logic [fsh_pkg::DIV_DEN_W:0]   rem_sh;
  logic [fsh_pkg::DIV_DEN_W:0]   diff;
  logic                          ge;

  always_comb begin
    rem_sh = {rem_r, num_r[fsh_pkg::DIV_NUM_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(fsh_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring long division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[fsh_pkg::DIV_NUM_W-2:0], 1'b0};
      rem_r <= ge ? diff[fsh_pkg::DIV_DEN_W-1:0] : rem_sh[fsh_pkg::DIV_DEN_W-1:0];
      quo_r <= {quo_r[fsh_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  assign resp.done = done_r;
  assign resp.quo  = quo_r;

endmodule

// ===== src/fsh_surf_ram.sv =====
module fsh_surf_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/fsh_fermi.sv =====
module fsh_fermi (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [30:0]          beta,
  input  fsh_pkg::fermi_req_t  req,
  output fsh_pkg::fermi_resp_t resp,
  output fsh_pkg::div_req_t    dreq,
  input  fsh_pkg::div_resp_t   dresp
);

  localparam logic [3:0] F_IDLE  = 4'd0;
  localparam logic [3:0] F_MLO   = 4'd1;
  localparam logic [3:0] F_MHI   = 4'd2;
  localparam logic [3:0] F_ARG   = 4'd3;
  localparam logic [3:0] F_TMUL  = 4'd4;
  localparam logic [3:0] F_TDIV  = 4'd5;
  localparam logic [3:0] F_EFIN  = 4'd6;
  localparam logic [3:0] F_EMUL  = 4'd7;
  localparam logic [3:0] F_DDIV  = 4'd8;
  localparam logic [3:0] F_DWAIT = 4'd9;

  logic [3:0]  st_r;
  logic        done_r;
  logic        pos_r;
  logic [34:0] mag_r;
  logic [48:0] plo_r;
  logic [47:0] phi_r;
  logic [23:0] arg_r;
  logic [31:0] fq_r;
  logic [31:0] term_r;
  logic [31:0] tm_r;
  logic [33:0] sum_r;
  logic [32:0] e_r;
  logic [3:0]  k_r;
  logic [7:0]  cnt_r;
  logic [16:0] f_r;

  logic [32:0] ma;
  logic [31:0] mb;
  logic [64:0] mp;
  logic [65:0] prod;
  logic        big;
  logic [23:0] arg;
  logic [33:0] den_c;
  logic [49:0] num_c;
  logic        req_pos;
  logic [32:0] magic;
  logic [2:0]  msh;
  logic [32:0] tq_w;
  logic [31:0] tq;

  // division by k as a multiply by the rounded-up reciprocal
  always_comb begin
    magic = 33'h1_0000_0000;
    msh   = 3'd0;
    case (k_r)
      4'd2:  begin magic = 33'h1_0000_0000; msh = 3'd1; end
      4'd3:  begin magic = 33'h1_5555_5556; msh = 3'd2; end
      4'd4:  begin magic = 33'h1_0000_0000; msh = 3'd2; end
      4'd5:  begin magic = 33'h1_9999_999A; msh = 3'd3; end
      4'd6:  begin magic = 33'h1_5555_5556; msh = 3'd3; end
      4'd7:  begin magic = 33'h1_2492_4925; msh = 3'd3; end
      4'd8:  begin magic = 33'h1_0000_0000; msh = 3'd3; end
      4'd9:  begin magic = 33'h1_C71C_71C8; msh = 3'd4; end
      4'd10: begin magic = 33'h1_9999_999A; msh = 3'd4; end
      4'd11: begin magic = 33'h1_745D_1746; msh = 3'd4; end
      4'd12: begin magic = 33'h1_5555_5556; msh = 3'd4; end
      default: begin
        magic = 33'h1_0000_0000;
        msh   = 3'd0;
      end
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_r)
      F_MLO: begin
        ma = {2'b0, beta};
        mb = {14'b0, mag_r[17:0]};
      end
      F_MHI: begin
        ma = {2'b0, beta};
        mb = {15'b0, mag_r[34:18]};
      end
      F_TMUL: begin
        ma = {1'b0, term_r};
        mb = fq_r;
      end
      F_TDIV: begin
        ma = magic;
        mb = tm_r;
      end
      F_EMUL: begin
        ma = e_r;
        mb = {1'b0, fsh_pkg::EXP_NEG_ONE};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mp   = 65'(ma) * 65'(mb);
    tq_w = mp[64:32] >> msh;
    tq   = tq_w[31:0];
  end

  always_comb begin
    prod    = {17'b0, plo_r} + {phi_r, 18'b0};
    big     = prod > (66'd1 << 40);
    arg     = prod[40:17];
    den_c   = 34'h1_0000_0000 + {1'b0, e_r};
    num_c   = (pos_r && arg_r != '0) ? ({1'b0, e_r, 16'b0} + {17'b0, den_c[33:1]})
                                     : ((50'd1 << 48) + {17'b0, den_c[33:1]});
    req_pos = !req.d[34] && (req.d != '0);
  end

  always_comb begin
    dreq.start = (st_r == F_DDIV);
    dreq.num   = num_c;
    dreq.den   = den_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        F_IDLE: begin
          if (req.start) begin
            pos_r <= req_pos;
            mag_r <= req.d[34] ? 35'(-req.d) : 35'(req.d);
            st_r  <= F_MLO;
          end
        end
        F_MLO: begin
          plo_r <= mp[48:0];
          st_r  <= F_MHI;
        end
        F_MHI: begin
          phi_r <= mp[47:0];
          st_r  <= F_ARG;
        end
        F_ARG: begin
          if (big) begin
            f_r    <= pos_r ? 17'd0 : fsh_pkg::F_ONE;
            done_r <= 1'b1;
            st_r   <= F_IDLE;
          end else if (pos_r && arg > fsh_pkg::ARG_MAX) begin
            f_r    <= 17'd0;
            done_r <= 1'b1;
            st_r   <= F_IDLE;
          end else begin
            arg_r  <= arg;
            fq_r   <= {arg[15:0], 16'b0};
            term_r <= {arg[15:0], 16'b0};
            sum_r  <= 34'h1_0000_0000 - {2'b0, arg[15:0], 16'b0};
            k_r    <= 4'd2;
            cnt_r  <= arg[23:16];
            if (arg[23:16] >= fsh_pkg::WHOLE_LIMIT) begin
              e_r  <= '0;
              st_r <= F_DDIV;
            end else begin
              st_r <= F_TMUL;
            end
          end
        end
        F_TMUL: begin
          tm_r <= mp[63:32];
          st_r <= F_TDIV;
        end
        F_TDIV: begin
          term_r <= tq;
          // odd terms of the series subtract
          sum_r  <= k_r[0] ? sum_r - {2'b0, tq} : sum_r + {2'b0, tq};
          if (k_r == fsh_pkg::LAST_TERM) begin
            st_r <= F_EFIN;
          end else begin
            k_r  <= k_r + 4'd1;
            st_r <= F_TMUL;
          end
        end
        F_EFIN: begin
          e_r  <= sum_r[32:0];
          st_r <= (cnt_r == '0) ? F_DDIV : F_EMUL;
        end
        F_EMUL: begin
          // one factor of exp(-1) per whole unit
          e_r   <= {1'b0, mp[63:32]};
          cnt_r <= cnt_r - 8'd1;
          if (cnt_r == 8'd1) begin
            st_r <= F_DDIV;
          end
        end
        F_DDIV: begin
          st_r <= F_DWAIT;
        end
        F_DWAIT: begin
          if (dresp.done) begin
            f_r    <= dresp.quo[16:0];
            done_r <= 1'b1;
            st_r   <= F_IDLE;
          end
        end
        default: begin
          st_r <= F_IDLE;
        end
      endcase
    end
  end

  assign resp.done = done_r;
  assign resp.f    = f_r;

endmodule

// ===== src/fermi_stochastic_state_hop_top.sv =====
// two-state fermi surface hopping, one bead per input word
// in channel: in_valid/in_ready with in_data (bead, both surface energies,
//   random fraction, final flag). out channel: out_valid/out_ready with
//   out_data, exactly one result word per input word, in order.
// cfg channel: cfg_valid/cfg_ready (always ready), cfg_index and cfg_data;
//   write only while no word is in flight. unknown indexes are ignored.
// one word is worked on at a time; its two fermi factors are run one after
//   the other. a factor whose argument saturates ends after the argument
//   multiplies and check; one whose whole part is 24 or more goes on to the
//   quotient; any other runs a multiply and a divide by k for each of 11
//   series terms, a step to close the series, one multiply by exp(-1) per
//   whole unit of the argument, then the quotient through a shared radix-2
//   divider. the next word is taken in the cycle after the result is loaded
//   into the output register.
// surface bits live in a one-port-write, one-port-read ram read at accept.
// after reset a clearing pass writes surface zero to every bead with
//   in_ready low; cfg writes are taken throughout.
// the result sits in an output register; a stalled receiver holds it there
//   and the next word can still be accepted and worked on meanwhile.
module fermi_stochastic_state_hop_top #(
  parameter int BEAD_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fsh_pkg::fsh_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fsh_pkg::fsh_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int AW = (BEAD_COUNT > 1) ? $clog2(BEAD_COUNT) : 1;
  localparam int CW = $clog2(BEAD_COUNT + 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_FL   = 4'd3;
  localparam logic [3:0] S_FR   = 4'd4;
  localparam logic [3:0] S_P1   = 4'd5;
  localparam logic [3:0] S_P2   = 4'd6;
  localparam logic [3:0] S_P3   = 4'd7;
  localparam logic [3:0] S_P4   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]         st_r;
  logic [CW-1:0]      clr_r;
  logic [30:0]        gamma_r;
  logic [30:0]        dt_r;
  logic [30:0]        beta_r;
  logic [31:0]        bias_r;
  fsh_pkg::fsh_in_t   item_r;
  logic               inside_r;
  logic               surf_r;
  logic signed [39:0] acc_r;
  logic signed [39:0] tot_r;
  logic signed [31:0] active_r;
  logic [16:0]        fl_r;
  logic [17:0]        s_r;
  logic [48:0]        pa_r;
  logic [55:0]        glo_r;
  logic [54:0]        ghi_r;
  logic               hop_r;
  fsh_pkg::fsh_out_t  out_r;
  logic               out_valid_r;

  logic [AW-1:0]      in_addr;
  logic [AW-1:0]      item_addr;
  logic [15:0]        in_bead_ext;
  logic [15:0]        item_bead_ext;
  logic               in_inside;
  logic               rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic               mem_wdata;
  logic               surf_c;
  logic signed [31:0] active_c;
  logic signed [40:0] acc_sum;
  logic signed [39:0] acc_sat;
  logic signed [32:0] de;
  logic signed [34:0] d2;
  logic signed [34:0] bias_x;
  logic signed [34:0] d_left;
  logic signed [34:0] d_right;
  logic [17:0]        s_c;
  logic [80:0]        g_c;
  logic [48:0]        thr_c;
  logic               hop_c;
  logic               out_load;

  fsh_pkg::fermi_req_t  freq;
  fsh_pkg::fermi_resp_t fresp;
  fsh_pkg::div_req_t    dreq;
  fsh_pkg::div_resp_t   dresp;

  assign in_ready  = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    in_bead_ext   = {10'b0, in_data.bead_number};
    item_bead_ext = {10'b0, item_r.bead_number};
    in_addr       = in_bead_ext[AW-1:0];
    item_addr     = item_bead_ext[AW-1:0];
    in_inside     = {5'b0, in_data.bead_number} < 11'(BEAD_COUNT);
  end

  always_comb begin
    surf_c   = inside_r & rdata;
    active_c = surf_c ? item_r.energy_upper : item_r.energy_lower;
    acc_sum  = $signed({acc_r[39], acc_r}) + $signed({{9{active_c[31]}}, active_c});
    if (acc_sum[40] != acc_sum[39]) begin
      acc_sat = acc_sum[40] ? $signed({1'b1, 39'b0}) : $signed({1'b0, {39{1'b1}}});
    end else begin
      acc_sat = acc_sum[39:0];
    end
    de      = $signed({item_r.energy_upper[31], item_r.energy_upper})
            - $signed({item_r.energy_lower[31], item_r.energy_lower});
    d2      = $signed({de[32], de, 1'b0});
    bias_x  = $signed({{3{bias_r[31]}}, bias_r});
    d_left  = d2 - bias_x;
    d_right = d2 + bias_x;
    s_c     = {1'b0, fl_r} + {1'b0, fresp.f};
    g_c     = {1'b0, ghi_r, 25'b0} + {25'b0, glo_r};
    // hop when gamma*dt*s / 2^17 rounded down exceeds random * 2^16
    thr_c   = {item_r.random_fraction, 15'b0, 1'b1, 17'b0};
    hop_c   = g_c >= {32'b0, thr_c};
  end

  always_comb begin
    freq.start = (st_r == S_RD) || ((st_r == S_FL) && fresp.done);
    freq.d     = (st_r == S_RD) ? d_left : d_right;
  end

  always_comb begin
    mem_we    = (st_r == S_CLR) || ((st_r == S_P4) && hop_c && inside_r);
    mem_waddr = (st_r == S_CLR) ? clr_r[AW-1:0] : item_addr;
    mem_wdata = (st_r == S_CLR) ? 1'b0 : ~surf_r;
  end

  assign out_load = (st_r == S_OUT) && (!out_valid_r || out_ready);

  fsh_surf_ram #(
    .DEPTH (BEAD_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (in_addr),
    .rdata (rdata)
  );

  fsh_fermi u_fermi (
    .clk   (clk),
    .rst_n (rst_n),
    .beta  (beta_r),
    .req   (freq),
    .resp  (fresp),
    .dreq  (dreq),
    .dresp (dresp)
  );

  fsh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .resp  (dresp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= '0;
      dt_r    <= '0;
      beta_r  <= '0;
      bias_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fsh_pkg::CFG_COUPLING:  gamma_r <= cfg_data[30:0];
        fsh_pkg::CFG_TIME_STEP: dt_r    <= cfg_data[30:0];
        fsh_pkg::CFG_BETA:      beta_r  <= cfg_data[30:0];
        fsh_pkg::CFG_BIAS:      bias_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + CW'(1);
          if (clr_r == CW'(BEAD_COUNT - 1)) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_r   <= in_data;
            inside_r <= in_inside;
            st_r     <= S_RD;
          end
        end
        S_RD: begin
          surf_r   <= surf_c;
          active_r <= active_c;
          if (item_r.final_bead) begin
            tot_r <= acc_sat;
            acc_r <= '0;
          end else begin
            acc_r <= acc_sat;
          end
          st_r <= S_FL;
        end
        S_FL: begin
          if (fresp.done) begin
            fl_r <= fresp.f;
            st_r <= S_FR;
          end
        end
        S_FR: begin
          if (fresp.done) begin
            s_r  <= surf_r ? (18'h20000 - s_c) : s_c;
            st_r <= S_P1;
          end
        end
        S_P1: begin
          pa_r <= 49'(dt_r) * 49'(s_r);
          st_r <= S_P2;
        end
        S_P2: begin
          glo_r <= 56'(gamma_r) * 56'(pa_r[24:0]);
          st_r  <= S_P3;
        end
        S_P3: begin
          ghi_r <= 55'(gamma_r) * 55'(pa_r[48:25]);
          st_r  <= S_P4;
        end
        S_P4: begin
          hop_r <= hop_c;
          st_r  <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_r.active_energy <= active_r;
            out_r.hopped        <= hop_r;
            out_r.new_surface   <= surf_r ^ hop_r;
            out_r.energy_total  <= item_r.final_bead ? tot_r : 40'sd0;
            out_r.last          <= item_r.final_bead;
            st_r                <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/fsh_checker.sv =====
`include "fermi_stochastic_state_hop_top_assert.svh"

module fsh_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input fsh_pkg::fsh_out_t out_data
);

  `FSH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
  `FSH_ASSERT_IMP(a_total_only_last, out_valid && !out_data.last, out_data.energy_total == 40'sd0, "energy total set on a word that is not last")
  `FSH_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second word taken while one is in flight")

endmodule

bind fermi_stochastic_state_hop_top fsh_checker u_fsh_checker (.*);

// ===== sim/fermi_stochastic_state_hop_top_test.sv =====
`timescale 1ns / 100ps

module fermi_stochastic_state_hop_top_test;

  localparam int          BEADS     = 64;
  localparam int          DRAIN_CYC = 1500;
  localparam logic [63:0] ONE_Q32   = 64'd4294967296;
  localparam logic [63:0] ARG_LIM   = 64'd1099511627776;
  localparam longint      SUM_MAX   = 64'sd549755813887;
  localparam longint      SUM_MIN   = -64'sd549755813888;
  localparam logic [7:0]  CFG_BOGUS = 8'd7;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  fsh_pkg::fsh_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  fsh_pkg::fsh_out_t out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        cfg_index;
  logic [31:0]       cfg_data;

  fsh_pkg::fsh_in_t  bead_words[$];
  fsh_pkg::fsh_out_t hop_results[$];

  // predictor state
  logic [63:0] gamma_q, dt_q, beta_q;
  longint      bias_q;
  logic        surface_q[BEADS];
  longint      energy_sum_q;

  bit in_taken;
  bit quiet;
  int in_gap, out_gap;
  bit failed;

  fermi_stochastic_state_hop_top #(.BEAD_COUNT(BEADS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // exp(-x), x in Q16.16, result in Q0.32
  function automatic logic [63:0] exp_neg_q32(logic [63:0] x);
    logic [63:0] whole, fq, term, e;
    longint      acc;
    whole = x >> 16;
    fq    = (x & 64'hFFFF) << 16;
    term  = ONE_Q32;
    acc   = longint'(ONE_Q32);
    if (whole >= 24) return 64'd0;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * fq) >> 32) / k;
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    e = acc;
    for (logic [63:0] i = 0; i < whole; i++) e = (e * fsh_pkg::EXP_NEG_ONE) >> 32;
    return e;
  endfunction

  // fermi factor in Q1.16, d in units of 2^-17
  function automatic logic [63:0] fermi_q16(longint d);
    bit          pos;
    logic [63:0] mag, arg, e, den;
    pos = d > 0;
    mag = pos ? d : -d;
    if (beta_q != 0 && mag > ARG_LIM / beta_q) return pos ? 64'd0 : 64'd65536;
    arg = (beta_q * mag) >> 17;
    if (pos && arg > fsh_pkg::ARG_MAX) return 64'd0;
    e   = exp_neg_q32(arg);
    den = ONE_Q32 + e;
    if (pos && arg != 0) return ((e << 16) + den / 2) / den;
    return ((64'd1 << 48) + den / 2) / den;
  endfunction

  function automatic fsh_pkg::fsh_out_t hop_predict(fsh_pkg::fsh_in_t w);
    fsh_pkg::fsh_out_t r;
    logic              surf;
    longint            el, eu, act, de;
    logic [63:0]       s, gd, p;
    bit                hop;
    el   = w.energy_lower;
    eu   = w.energy_upper;
    surf = surface_q[w.bead_number];
    act  = surf ? eu : el;
    de   = eu - el;
    energy_sum_q += act;
    if (energy_sum_q > SUM_MAX) energy_sum_q = SUM_MAX;
    if (energy_sum_q < SUM_MIN) energy_sum_q = SUM_MIN;
    s = fermi_q16(2 * de - bias_q) + fermi_q16(2 * de + bias_q);
    if (surf) s = (64'd1 << 17) - s;
    gd = gamma_q * dt_q;
    if (s == 0) p = 0;
    else if (gd >= ((64'd1 << 49) + s - 1) / s) p = ONE_Q32;
    else p = (gd * s) >> 17;
    hop = p > (64'(w.random_fraction) << 16);
    if (hop) begin
      surf = ~surf;
      surface_q[w.bead_number] = surf;
    end
    r.active_energy = act[31:0];
    r.hopped        = hop;
    r.new_surface   = surf;
    if (w.final_bead) begin
      r.energy_total = energy_sum_q[39:0];
      r.last         = 1'b1;
      energy_sum_q   = 0;
    end else begin
      r.energy_total = '0;
      r.last         = 1'b0;
    end
    return r;
  endfunction

  // accept side and result check
  always @(posedge clk) begin
    fsh_pkg::fsh_out_t want;
    if (rst_n && in_valid && in_ready) begin
      hop_results.push_back(hop_predict(in_data));
      in_taken = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (hop_results.size() == 0) begin
        $error("result word with nothing expected");
        failed = 1'b1;
      end else begin
        want = hop_results.pop_front();
        if (out_data.active_energy !== want.active_energy) begin
          $error("active_energy exp %0d got %0d", want.active_energy,
                 out_data.active_energy);
          failed = 1'b1;
        end
        if (out_data.hopped !== want.hopped) begin
          $error("hopped exp %0d got %0d", want.hopped, out_data.hopped);
          failed = 1'b1;
        end
        if (out_data.new_surface !== want.new_surface) begin
          $error("new_surface exp %0d got %0d", want.new_surface, out_data.new_surface);
          failed = 1'b1;
        end
        if (out_data.energy_total !== want.energy_total) begin
          $error("energy_total exp %0d got %0d", want.energy_total,
                 out_data.energy_total);
          failed = 1'b1;
        end
        if (out_data.last !== want.last) begin
          $error("last exp %0d got %0d", want.last, out_data.last);
          failed = 1'b1;
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0 && !quiet) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (bead_words.size() > 0) begin
        in_data  <= bead_words.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(1, 19);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic reg_write(logic [7:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fsh_pkg::CFG_COUPLING:  gamma_q = val[30:0];
      fsh_pkg::CFG_TIME_STEP: dt_q    = val[30:0];
      fsh_pkg::CFG_BETA:      beta_q  = val[30:0];
      fsh_pkg::CFG_BIAS:      bias_q  = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] g, logic [31:0] t, logic [31:0] b, logic [31:0] v);
    reg_write(fsh_pkg::CFG_COUPLING, g);
    reg_write(fsh_pkg::CFG_TIME_STEP, t);
    reg_write(fsh_pkg::CFG_BETA, b);
    reg_write(fsh_pkg::CFG_BIAS, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (bead_words.size() > 0 || in_valid || hop_results.size() > 0) @(posedge clk);
  endtask

  function automatic fsh_pkg::fsh_in_t make_word(logic [5:0] bead, logic [31:0] el,
                                                 logic [31:0] eu, logic [15:0] rnd,
                                                 logic fin);
    fsh_pkg::fsh_in_t w;
    w.bead_number     = bead;
    w.energy_lower    = el;
    w.energy_upper    = eu;
    w.random_fraction = rnd;
    w.final_bead      = fin;
    return w;
  endfunction

  function automatic logic [31:0] rand_energy();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
  endfunction

  function automatic fsh_pkg::fsh_in_t rand_word();
    return make_word(6'($urandom_range(0, BEADS - 1)), rand_energy(), rand_energy(),
                     16'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0);
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom & 32'h7FFF_FFFF;
      default: return 32'($urandom_range(4096, 1 << 18));
    endcase
  endfunction

  task automatic random_phase(int n);
    repeat (n) bead_words.push_back(rand_word());
    wait_idle();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    gamma_q = 0; dt_q = 0; beta_q = 0; bias_q = 0;
    energy_sum_q = 0;
    foreach (surface_q[i]) surface_q[i] = 1'b0;
    in_taken = 0; quiet = 0; in_gap = 0; out_gap = 0; failed = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero coupling, zero beta: never hops
    bead_words.push_back(make_word(6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 1'b0));
    bead_words.push_back(make_word(6'd63, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b1));
    wait_idle();

    // unit rate, unit beta, no bias
    set_regs(32'd65536, 32'd65536, 32'd65536, 32'd0);
    reg_write(CFG_BOGUS, 32'hFFFF_FFFF);
    @(negedge clk);
    cfg_valid <= 1'b0;
    bead_words.push_back(make_word(6'd1, 32'd0, 32'd0, 16'd0, 1'b0));
    bead_words.push_back(make_word(6'd1, 32'd0, 32'd0, 16'hFFFF, 1'b0));
    bead_words.push_back(make_word(6'd2, 32'd0, 32'(-65536), 16'd100, 1'b0));
    bead_words.push_back(make_word(6'd2, 32'd0, 32'd65536 * 3, 16'd100, 1'b0));
    // large positive argument and huge argument both ways
    bead_words.push_back(make_word(6'd3, 32'd0, 32'd65536 * 60, 16'd0, 1'b0));
    bead_words.push_back(make_word(6'd3, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 1'b0));
    bead_words.push_back(make_word(6'd4, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 1'b1));
    bead_words.push_back(make_word(6'd4, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b1));
    wait_idle();

    // extremes of every register
    set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    bead_words.push_back(make_word(6'd5, 32'd1, 32'd0, 16'hFFFF, 1'b0));
    bead_words.push_back(make_word(6'd5, 32'd0, 32'd1, 16'hFFFF, 1'b0));
    bead_words.push_back(make_word(6'd6, 32'd0, 32'hC000_0000, 16'h8000, 1'b1));
    wait_idle();
    set_regs(32'h7FFF_FFFF, 32'd1, 32'd1, 32'h7FFF_FFFF);
    bead_words.push_back(make_word(6'd7, 32'd0, 32'd0, 16'd1, 1'b0));
    bead_words.push_back(make_word(6'd7, 32'hFFFF_0000, 32'h0001_0000, 16'd1, 1'b1));
    wait_idle();

    // accumulator saturation high then low
    set_regs(32'd0, 32'd65536, 32'd65536, 32'd0);
    for (int i = 0; i < 270; i++)
      bead_words.push_back(make_word(6'(i), 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     16'($urandom), i == 269));
    for (int i = 0; i < 270; i++)
      bead_words.push_back(make_word(6'(i), 32'h8000_0000, 32'h8000_0000,
                                     16'($urandom), i == 269));
    wait_idle();

    // random settings
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0) set_regs(32'd65536, 32'($urandom_range(1 << 12, 1 << 17)),
                                32'($urandom_range(1 << 14, 1 << 18)), $urandom);
      else set_regs(rand_rate(), rand_rate(), rand_rate(), $urandom);
      random_phase(90);
    end

    set_regs(32'd65536, 32'd32768, 32'd65536, 32'd16384);
    quiet = 1'b1;
    random_phase(200);
    repeat (DRAIN_CYC) @(posedge clk);
    if (!failed && hop_results.size() == 0) begin
      $display("fermi_stochastic_state_hop_top_test passed");
    end else begin
      $display("fermi_stochastic_state_hop_top_test failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("fermi_stochastic_state_hop_top_test failed");
    $finish;
  end

endmodule
